// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ----- rtl/fpa_pkg.sv -----
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_GT   = 4'd4,
        CMD_LT   = 4'd5,
        CMD_GE   = 4'd6,
        CMD_LE   = 4'd7,
        CMD_EQ   = 4'd8,
        CMD_NE   = 4'd9,
        CMD_INC  = 4'd10,
        CMD_DEC  = 4'd11,
        CMD_FINT = 4'd12
    } t_cmd;

    // Result item packed as on m_axis_tdata: value, flag, div_zero, then padding.
    typedef struct packed {
        logic [5:0]        pad;
        logic              div_zero;
        logic              flag;
        logic [DATA_W-1:0] value;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/fpa_div.sv -----
`default_nettype none
`include "assert_macros.svh"
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
module fpa_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);
    import fpa_pkg::*;

    logic [NUM_W-1:0] r_quo [1:NUM_W];
    logic [DEN_W:0]   r_rem [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] n_quo_in;
        logic [DEN_W:0]   n_rem_in;
        logic [DEN_W-1:0] n_den_in;
        logic [DEN_W+1:0] n_trial;
        logic [DEN_W:0]   n_shift;
        if (s == 0) begin : g_first
            assign n_quo_in = i_num;
            assign n_rem_in = '0;
            assign n_den_in = i_den;
        end else begin : g_next
            assign n_quo_in = r_quo[s];
            assign n_rem_in = r_rem[s];
            assign n_den_in = r_den[s];
        end
        assign n_shift = {n_rem_in[DEN_W-1:0], n_quo_in[NUM_W-1]};
        assign n_trial = {1'b0, n_shift} - {2'b00, n_den_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= n_den_in;
                if (!n_trial[DEN_W+1]) begin
                    r_rem[s+1] <= n_trial[DEN_W:0];
                    r_quo[s+1] <= {n_quo_in[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_shift;
                    r_quo[s+1] <= {n_quo_in[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[NUM_W];

    `ASSERT_IMPL(a_rem_lt_den, i_clk, i_rst_n,
        !$past(i_en) || r_den[1] == '0 || r_rem[1] < {1'b0, r_den[1]},
        "divider remainder not below divisor")

endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu_top.sv -----
// Q24.8 signed fixed-point ALU, stream in and stream out.
// Input item on s_axis: tdata = {cmd[3:0], operand_b[31:0], operand_a[31:0]}
// from the low bit up: operand_a, operand_b, cmd (4 bits), zero padding to 72.
// Result item on m_axis: tdata = value[31:0], flag, div_zero, zero padding to 40.
// Operations: add, sub, mul, div, six compares, inc, dec and integer to fixed.
// Every item runs through one pipeline of FRAC_BITS+35 stages: a divide needs
// one stage per quotient bit (32+FRAC_BITS), plus entry, sign and output stages.
// Every operation takes this same path, so that results leave in order.
// Throughput is one item per cycle: the whole pipeline advances whenever the
// output register is empty or being taken, and holds otherwise.
// When the receiver stalls, the pipeline freezes and s_axis_tready falls
// only if the output register holds an item that is not taken; nothing is
// lost or repeated. Reset clears the valid bits; data registers are not reset.
// Division by zero returns value 0 with div_zero set.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_top #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operand_a [31:0], operand_b [63:32], cmd [67:64], zeros [71:68]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // value [31:0], flag [32], div_zero [33], zeros [39:34]
    output logic      [39:0] m_axis_tdata
);
    import fpa_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 0: input register.
    logic                     r_v0;
    logic [CMD_W-1:0]         r_cmd0;
    logic signed [DATA_W-1:0] r_a0, r_b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= s_axis_tvalid;
        end
        if (adv) begin
            r_a0   <= s_axis_tdata[31:0];
            r_b0   <= s_axis_tdata[63:32];
            r_cmd0 <= s_axis_tdata[67:64];
        end
    end

    // Stage 1: simple results, product register, divider operand preparation.
    logic                     r_v1;
    t_result                  r_res1;
    logic [CMD_W-1:0]         r_cmd1;
    logic signed [2*DATA_W-1:0] r_prod1;
    logic                     r_qneg1;
    logic                     r_dz1;
    logic [NUM_W-1:0]         r_num1;
    logic [DATA_W-1:0]        r_den1;
    t_result                  n_res1;
    logic [DATA_W-1:0]        n_absa, n_absb;

    always_comb begin
        n_res1 = '0;
        n_absa = r_a0[DATA_W-1] ? DATA_W'(-r_a0) : DATA_W'(r_a0);
        n_absb = r_b0[DATA_W-1] ? DATA_W'(-r_b0) : DATA_W'(r_b0);
        case (r_cmd0)
            CMD_ADD:  n_res1.value = r_a0 + r_b0;
            CMD_SUB:  n_res1.value = r_a0 - r_b0;
            CMD_GT:   n_res1.flag  = r_a0 > r_b0;
            CMD_LT:   n_res1.flag  = r_a0 < r_b0;
            CMD_GE:   n_res1.flag  = r_a0 >= r_b0;
            CMD_LE:   n_res1.flag  = r_a0 <= r_b0;
            CMD_EQ:   n_res1.flag  = r_a0 == r_b0;
            CMD_NE:   n_res1.flag  = r_a0 != r_b0;
            CMD_INC:  n_res1.value = r_a0 + DATA_W'(1);
            CMD_DEC:  n_res1.value = r_a0 - DATA_W'(1);
            CMD_FINT: n_res1.value = r_a0 << FRAC_BITS;
            default:  n_res1 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v0;
        end
        if (adv) begin
            r_res1  <= n_res1;
            r_cmd1  <= r_cmd0;
            r_prod1 <= r_a0 * r_b0;
            r_qneg1 <= r_a0[DATA_W-1] ^ r_b0[DATA_W-1];
            r_dz1   <= (r_b0 == '0);
            r_num1  <= {n_absa, FRAC_BITS'(0)};
            r_den1  <= n_absb;
        end
    end

    // Divider stages; the other fields travel alongside in a delay line.
    logic [NUM_W-1:0] w_quo;
    fpa_div #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_num   (r_num1),
        .i_den   (r_den1),
        .o_quo   (w_quo)
    );

    logic             r_vd   [NUM_W];
    t_result          r_resd [NUM_W];
    logic [CMD_W-1:0] r_cmdd [NUM_W];
    logic             r_qnd  [NUM_W];
    logic             r_dzd  [NUM_W];

    // Product shift happens in the first delay stage, after the multiplier register.
    logic signed [2*DATA_W-1:0] n_shprod;
    t_result                    n_resd0;
    assign n_shprod = r_prod1 >>> FRAC_BITS;

    always_comb begin
        n_resd0 = r_res1;
        if (r_cmd1 == CMD_MUL) n_resd0.value = n_shprod[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_W; i++) r_vd[i] <= 1'b0;
        end else if (adv) begin
            r_vd[0] <= r_v1;
            for (int i = 1; i < NUM_W; i++) r_vd[i] <= r_vd[i-1];
        end
        if (adv) begin
            r_resd[0] <= n_resd0;
            r_cmdd[0] <= r_cmd1;
            r_qnd[0]  <= r_qneg1;
            r_dzd[0]  <= r_dz1;
            for (int i = 1; i < NUM_W; i++) begin
                r_resd[i] <= r_resd[i-1];
                r_cmdd[i] <= r_cmdd[i-1];
                r_qnd[i]  <= r_qnd[i-1];
                r_dzd[i]  <= r_dzd[i-1];
            end
        end
    end

    // Output stage: sign the quotient and pick the result.
    t_result n_out;
    logic [DATA_W-1:0] n_q32;
    always_comb begin
        n_out = r_resd[NUM_W-1];
        n_q32 = w_quo[DATA_W-1:0];
        if (r_cmdd[NUM_W-1] == CMD_DIV) begin
            n_out = '0;
            if (r_dzd[NUM_W-1]) n_out.div_zero = 1'b1;
            else n_out.value = r_qnd[NUM_W-1] ? (DATA_W'(0) - n_q32) : n_q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            m_axis_tvalid <= r_vd[NUM_W-1];
        end
        if (adv) m_axis_tdata <= n_out;
    end

    `ASSERT_IMPL(a_ready_when_free, i_clk, i_rst_n,
        !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    `ASSERT_IMPL(a_hold_on_stall, i_clk, i_rst_n,
        $past(m_axis_tvalid && !m_axis_tready) |-> $stable(m_axis_tdata),
        "result changed while stalled")
    `ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata[39:34] == '0 && !(m_axis_tdata[32] && m_axis_tdata[33])),
        "bad result padding or flags")

endmodule
`default_nettype wire
